### hw/rtl/segment_min_fingerprint_feature_top_macros.svh
// Assertion macros shared by the segment feature RTL.
`ifndef SEGMENT_MIN_FINGERPRINT_FEATURE_TOP_MACROS_SVH
`define SEGMENT_MIN_FINGERPRINT_FEATURE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SMFF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMFF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/smff_pkg.sv
// Shared constants and types for the segment feature block.
`default_nettype none
package smff_pkg;

  localparam int FP_W          = 160;
  localparam int OUT_LEN_W     = 20;
  localparam int CFG_W         = 24;
  localparam int USED_W        = 25;
  localparam int ADDR_W        = 3;
  localparam int PDATA_W       = 32;

  localparam int DEFAULT_DEPTH       = 32;
  localparam int DEFAULT_LENGTH_BITS = 20;

  localparam logic [CFG_W-1:0] BUDGET_RESET = 24'd2048;
  localparam logic [CFG_W-1:0] COST_RESET   = 24'd64;

  // register index, taken from paddr[2]
  localparam logic REG_BUDGET = 1'b0;
  localparam logic REG_COST   = 1'b1;

  // action codes; file end and the spare code are consumed silently
  localparam logic [1:0] ACT_CHUNK      = 2'd0;
  localparam logic [1:0] ACT_STREAM_END = 2'd2;

  typedef struct packed {
    logic shift;   // every cell takes its upstream neighbor
    logic insert;  // first empty cell loads the broadcast entry
  } cell_ctrl_t;

  typedef struct packed {
    logic head_valid;
    logic next_valid;  // cell behind the head holds an entry
    logic full;
  } chain_stat_t;

endpackage
`default_nettype wire

### hw/rtl/smff_cell.sv
// One buffer cell of the segment chain.
`default_nettype none
module smff_cell #(
  parameter int DATA_W = 180
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire smff_pkg::cell_ctrl_t ctrl,
  input  wire                      prev_valid,
  input  wire                      next_valid,
  input  wire [DATA_W-1:0]         next_data,
  input  wire [DATA_W-1:0]         in_data,
  output logic                     valid,
  output logic [DATA_W-1:0]        data
);

  logic take;

  // the entry lands in the first empty cell behind a full one
  assign take = ctrl.insert && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= next_data;
    end else if (take) begin
      data <= in_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/smff_chain.sv
// Row of buffer cells; head is the oldest entry, entries shift toward it.
`default_nettype none
`include "segment_min_fingerprint_feature_top_macros.svh"
module smff_chain #(
  parameter int DEPTH  = smff_pkg::DEFAULT_DEPTH,
  parameter int DATA_W = smff_pkg::FP_W + smff_pkg::DEFAULT_LENGTH_BITS
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire smff_pkg::cell_ctrl_t  ctrl,
  input  wire [DATA_W-1:0]          in_data,
  output logic [DATA_W-1:0]         head_data,
  output smff_pkg::chain_stat_t     stat
);

  logic [DEPTH-1:0]  vld;
  logic [DATA_W-1:0] dat [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              pv;
    logic              nv;
    logic [DATA_W-1:0] nd;

    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_mid
      assign pv = vld[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_inner
      assign nv = vld[i+1];
      assign nd = dat[i+1];
    end

    smff_cell #(.DATA_W(DATA_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (pv),
      .next_valid (nv),
      .next_data  (nd),
      .in_data    (in_data),
      .valid      (vld[i]),
      .data       (dat[i])
    );
  end

  assign head_data       = dat[0];
  assign stat.head_valid = vld[0];
  assign stat.next_valid = g_cell[0].nv;
  assign stat.full       = vld[DEPTH-1];

  logic [DEPTH-1:0] vld_inc;
  assign vld_inc = vld + DEPTH'(1);

  // occupied cells always form an unbroken run from the head
  `SMFF_ASSERT_IMP(a_contiguous, clk, rst, 1'b1, (vld & vld_inc) == '0,
                   "chain has a hole")

endmodule
`default_nettype wire

### hw/rtl/segment_min_fingerprint_feature_top.sv
// Segment feature top: chunk buffer chain, running minimum, flush control.
// Chunk with no flush: accepted and stored directly, no result.
// Flush: one result per cycle out of the head cell while the output is free, then the held chunk is stored.
// Stream end: flush as above without the chunk store, then the end marker.
// Output register decouples the sides; a stalled output stalls the chain shift.
// Synchronous active-high rst empties the chain and restores register defaults.
`default_nettype none
`include "segment_min_fingerprint_feature_top_macros.svh"
module segment_min_fingerprint_feature_top #(
  parameter int SEGMENT_DEPTH = smff_pkg::DEFAULT_DEPTH,
  parameter int LENGTH_BITS   = smff_pkg::DEFAULT_LENGTH_BITS
) (
  input  wire         clk,
  input  wire         rst,
  // request channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [1:0]   action,
  input  wire [31:0]  fp_top,
  input  wire [63:0]  fp_middle,
  input  wire [63:0]  fp_bottom,
  input  wire [19:0]  chunk_length,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_fp_top,
  output logic [63:0] out_fp_middle,
  output logic [63:0] out_fp_bottom,
  output logic [19:0] out_chunk_length,
  output logic [31:0] feature_top,
  output logic [63:0] feature_middle,
  output logic [63:0] feature_bottom,
  output logic        end_marker,
  output logic        last_of_run,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [smff_pkg::ADDR_W-1:0]  paddr,
  input  wire [smff_pkg::PDATA_W-1:0] pwdata,
  output logic [smff_pkg::PDATA_W-1:0] prdata,
  output logic        pready
);

  localparam int FpW    = smff_pkg::FP_W;
  localparam int CfgW   = smff_pkg::CFG_W;
  localparam int UsedW  = smff_pkg::USED_W;
  localparam int LenOutW = smff_pkg::OUT_LEN_W;
  localparam int DataW  = FpW + LENGTH_BITS;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_INS   = 4'b0100,
    ST_MARK  = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [CfgW-1:0] segment_budget;
  logic [CfgW-1:0] item_cost;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_budget <= smff_pkg::BUDGET_RESET;
      item_cost      <= smff_pkg::COST_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        smff_pkg::REG_BUDGET: segment_budget <= pwdata[CfgW-1:0];
        smff_pkg::REG_COST:   item_cost      <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      smff_pkg::REG_BUDGET: prdata = smff_pkg::PDATA_W'(segment_budget);
      smff_pkg::REG_COST:   prdata = smff_pkg::PDATA_W'(item_cost);
      default:              prdata = '0;
    endcase
  end

  // segment state
  logic [UsedW-1:0]      used;
  logic [UsedW-1:0]      used_next;
  logic [FpW-1:0]        cur_min;
  logic [FpW-1:0]        cur_min_next;

  // request held across a flush
  logic [FpW-1:0]         pend_fp;
  logic [LENGTH_BITS-1:0] pend_len;
  logic                   pend_chunk;

  logic [FpW-1:0]         in_fp;
  logic                   in_acc;
  logic                   is_chunk;
  logic                   over_budget;
  logic                   need_flush;
  logic                   load_out;
  logic [FpW-1:0]         min_base;

  smff_pkg::cell_ctrl_t   ctrl;
  smff_pkg::chain_stat_t  stat;
  logic [DataW-1:0]       ins_data;
  logic [DataW-1:0]       head_data;

  logic                   emit_head;
  logic                   emit_mark;
  logic                   emit_last;

  assign in_fp      = {fp_top, fp_middle, fp_bottom};
  assign in_ready   = (state == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign is_chunk   = (action == smff_pkg::ACT_CHUNK);
  assign load_out   = !out_valid || out_ready;
  // 26-bit sum keeps the compare exact
  assign over_budget = ({1'b0, used} + (UsedW+1)'(item_cost)) > (UsedW+1)'(segment_budget);
  assign need_flush  = over_budget || stat.full;
  // segment restarts when the flush finds nothing held
  assign min_base    = need_flush ? '1 : cur_min;

  always_comb begin
    state_next   = state;
    used_next    = used;
    cur_min_next = cur_min;
    ctrl         = '0;
    ins_data     = {in_fp, LENGTH_BITS'(chunk_length)};
    emit_head    = 1'b0;
    emit_mark    = 1'b0;
    emit_last    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_chunk) begin
            if (need_flush && stat.head_valid) begin
              state_next = ST_FLUSH;
            end else begin
              ctrl.insert  = 1'b1;
              cur_min_next = (in_fp < min_base) ? in_fp : min_base;
              used_next    = (need_flush ? '0 : used) + UsedW'(item_cost);
            end
          end else if (action == smff_pkg::ACT_STREAM_END) begin
            state_next = stat.head_valid ? ST_FLUSH : ST_MARK;
          end
        end
      end
      ST_FLUSH: begin
        if (load_out) begin
          ctrl.shift = 1'b1;
          emit_head  = 1'b1;
          if (!stat.next_valid) begin
            emit_last  = pend_chunk;
            state_next = pend_chunk ? ST_INS : ST_MARK;
          end
        end
      end
      ST_INS: begin
        // fresh segment: the new chunk alone sets the minimum
        ctrl.insert  = 1'b1;
        ins_data     = {pend_fp, pend_len};
        cur_min_next = pend_fp;
        used_next    = UsedW'(item_cost);
        state_next   = ST_IDLE;
      end
      ST_MARK: begin
        if (load_out) begin
          emit_mark    = 1'b1;
          cur_min_next = '1;
          used_next    = '0;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      used    <= '0;
      cur_min <= '1;
    end else begin
      state   <= state_next;
      used    <= used_next;
      cur_min <= cur_min_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_fp    <= in_fp;
      pend_len   <= LENGTH_BITS'(chunk_length);
      pend_chunk <= is_chunk;
    end
  end

  smff_chain #(.DEPTH(SEGMENT_DEPTH), .DATA_W(DataW)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_data   (ins_data),
    .head_data (head_data),
    .stat      (stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_head || emit_mark) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_head) begin
      {out_fp_top, out_fp_middle, out_fp_bottom} <= head_data[DataW-1 -: FpW];
      out_chunk_length <= LenOutW'(head_data[LENGTH_BITS-1:0]);
      {feature_top, feature_middle, feature_bottom} <= cur_min;
      end_marker  <= 1'b0;
      last_of_run <= emit_last;
    end else if (emit_mark) begin
      {out_fp_top, out_fp_middle, out_fp_bottom}    <= '0;
      out_chunk_length                              <= '0;
      {feature_top, feature_middle, feature_bottom} <= '0;
      end_marker  <= 1'b1;
      last_of_run <= 1'b1;
    end
  end

  `SMFF_ASSERT_IMP(a_flush_has_head, clk, rst, state == ST_FLUSH, stat.head_valid,
                   "flush running with empty head cell")
  `SMFF_ASSERT_IMP(a_used_means_held, clk, rst, (state == ST_IDLE) && (used != '0),
                   stat.head_valid, "budget charged but no chunk held")
  `SMFF_ASSERT_NXT(a_mark_resets, clk, rst, emit_mark,
                   (state == ST_IDLE) && (used == '0) && (cur_min == '1),
                   "end marker did not reset the segment")
  `SMFF_ASSERT_IMP(a_mark_is_last, clk, rst, out_valid && end_marker, last_of_run,
                   "end marker not flagged last")

endmodule
`default_nettype wire
